/* rtl/mvcc_pkg.sv */
// Package for the operation timestamp tracker: payload words, request and
// status codes, sequencer states. No dependencies.
package mvcc_pkg;

    typedef enum logic [2:0] {
        REQ_START       = 3'd0,
        REQ_START_APPLY = 3'd1,
        REQ_FINISH      = 3'd2,
        REQ_ABORT       = 3'd3,
        REQ_RAISE       = 3'd4,
        REQ_QUERY       = 3'd5,
        REQ_CLOSE       = 3'd6,
        REQ_NONE        = 3'd7
    } req_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_WRONG_STATE  = 3'd2,
        ST_ALREADY      = 3'd3,
        ST_BELOW_OR_DUP = 3'd4,
        ST_TABLE_FULL   = 3'd5,
        ST_LIST_FULL    = 3'd6,
        ST_SPARE        = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MIN,
        S_FILTER,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] op_time;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] clean_time;
        logic        all_done_before;
        logic        any_in_flight_at_or_before;
        logic [63:0] upper_mark;
    } out_word_t;

endpackage

/* rtl/mvcc_op_timestamp_tracker.sv */
// Top level of the operation timestamp tracker: tables, sequencer, output register.
// Depends on mvcc_pkg.
// The scan pass visits both tables, one entry per cycle. A decide step follows, then a minimum
// pass over the in-flight table and a filter pass over the applied list, each only when the
// request needs it; then the result word is registered.
// Throughput: one request at a time; in_ready is high only in idle, entered in the cycle after the
// result word is loaded, later while an unread result is held.
// Reset: asynchronous, active low; clears valid bits and the watermarks.
module mvcc_op_timestamp_tracker #(
    parameter int INFLIGHT_DEPTH = 16,
    parameter int APPLIED_DEPTH  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mvcc_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mvcc_pkg::out_word_t out_data
);
    import mvcc_pkg::*;

    localparam int SCAN_N = (INFLIGHT_DEPTH > APPLIED_DEPTH) ? INFLIGHT_DEPTH : APPLIED_DEPTH;
    localparam int CW = $clog2(SCAN_N + 1);
    localparam int FW = $clog2(INFLIGHT_DEPTH);
    localparam int AW = $clog2(APPLIED_DEPTH);
    localparam logic [63:0] MAXT = '1;

    logic [INFLIGHT_DEPTH-1:0] fvalid_reg, fapply_reg;
    logic [63:0] ftime_reg [INFLIGHT_DEPTH];
    logic [APPLIED_DEPTH-1:0] avalid_reg;
    logic [63:0] atime_reg [APPLIED_DEPTH];
    logic [63:0] earliest_reg, bound_reg, clean_reg, none_reg;
    logic        open_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    req_t        req_reg;
    logic [63:0] t_reg;
    logic        found_reg, ffree_ok_reg, afree_ok_reg, inlist_reg, before_reg, any_reg;
    logic [FW-1:0] idx_reg, ffree_reg;
    logic [AW-1:0] afree_reg;
    logic [63:0] min_reg;
    logic        ovalid_reg;
    out_word_t   odata_reg;
    logic [2:0]  st_reg;
    logic        do_min_reg, do_filter_reg;

    status_t     dec_st;
    logic        dec_min, dec_filter;

    logic [FW-1:0] fi;
    logic [AW-1:0] ai;
    logic          fin, ain;
    assign fi  = cnt_reg[FW-1:0];
    assign ai  = cnt_reg[AW-1:0];
    assign fin = {{(32-CW){1'b0}}, cnt_reg} < 32'(INFLIGHT_DEPTH);
    assign ain = {{(32-CW){1'b0}}, cnt_reg} < 32'(APPLIED_DEPTH);

    logic applied_t;
    assign applied_t = (t_reg < clean_reg) || ((t_reg < none_reg) && inlist_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_SCAN;
            S_SCAN:   if (cnt_reg == CW'(SCAN_N - 1)) state_next = S_DECIDE;
            S_DECIDE: state_next = S_MIN;
            S_MIN:    if (!do_min_reg || cnt_reg == CW'(INFLIGHT_DEPTH)) state_next = S_FILTER;
            S_FILTER: if (!do_filter_reg || cnt_reg == CW'(APPLIED_DEPTH)) state_next = S_OUT;
            S_OUT:    if (!ovalid_reg || out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        dec_st     = ST_OK;
        dec_min    = 1'b0;
        dec_filter = 1'b0;
        unique case (req_reg)
            REQ_START:
                if (applied_t) dec_st = ST_ALREADY;
                else if (t_reg <= bound_reg || found_reg) dec_st = ST_BELOW_OR_DUP;
                else if (!ffree_ok_reg) dec_st = ST_TABLE_FULL;
            REQ_START_APPLY:
                if (!found_reg) dec_st = ST_NOT_FOUND;
                else if (fapply_reg[idx_reg]) dec_st = ST_WRONG_STATE;
            REQ_FINISH:
                if (!found_reg) dec_st = ST_NOT_FOUND;
                else if (!fapply_reg[idx_reg]) dec_st = ST_WRONG_STATE;
                else if (!applied_t && !afree_ok_reg) dec_st = ST_LIST_FULL;
                else if (earliest_reg == t_reg)
                begin
                    dec_min    = 1'b1;
                    dec_filter = (bound_reg >= t_reg);
                end
            REQ_ABORT:
                if (!found_reg) dec_st = ST_NOT_FOUND;
                else if (open_reg && fapply_reg[idx_reg]) dec_st = ST_WRONG_STATE;
                else dec_min = open_reg && (earliest_reg == t_reg);
            REQ_RAISE:
                dec_filter = (bound_reg <= t_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fvalid_reg   <= '0;
            avalid_reg   <= '0;
            earliest_reg <= MAXT;
            bound_reg    <= '0;
            clean_reg    <= 64'd1;
            none_reg     <= 64'd1;
            open_reg     <= 1'b1;
            ovalid_reg   <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && out_ready && state_reg != S_OUT)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= req_t'(in_data.req_type);
                        t_reg   <= in_data.op_time;
                        cnt_reg <= '0;
                        found_reg <= 1'b0; ffree_ok_reg <= 1'b0; afree_ok_reg <= 1'b0;
                        inlist_reg <= 1'b0; any_reg <= 1'b0; before_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (fin)
                    begin
                        if (fvalid_reg[fi] && ftime_reg[fi] == t_reg && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            idx_reg   <= fi;
                        end
                        if (!fvalid_reg[fi] && !ffree_ok_reg)
                        begin
                            ffree_ok_reg <= 1'b1;
                            ffree_reg    <= fi;
                        end
                        if (fvalid_reg[fi] && ftime_reg[fi] <= t_reg)
                            before_reg <= 1'b1;
                    end
                    if (ain)
                    begin
                        if (avalid_reg[ai] && atime_reg[ai] == t_reg)
                            inlist_reg <= 1'b1;
                        if (!avalid_reg[ai] && !afree_ok_reg)
                        begin
                            afree_ok_reg <= 1'b1;
                            afree_reg    <= ai;
                        end
                    end
                end
                S_DECIDE:
                begin
                    cnt_reg       <= '0;
                    min_reg       <= MAXT;
                    st_reg        <= dec_st;
                    do_min_reg    <= dec_min;
                    do_filter_reg <= dec_filter;
                    if (dec_st == ST_OK)
                    begin
                        unique case (req_reg)
                            REQ_START:
                            begin
                                fvalid_reg[ffree_reg] <= 1'b1;
                                fapply_reg[ffree_reg] <= 1'b0;
                                ftime_reg[ffree_reg]  <= t_reg;
                                if (t_reg < earliest_reg) earliest_reg <= t_reg;
                            end
                            REQ_START_APPLY:
                                fapply_reg[idx_reg] <= 1'b1;
                            REQ_FINISH:
                            begin
                                fvalid_reg[idx_reg] <= 1'b0;
                                if (!applied_t)
                                begin
                                    avalid_reg[afree_reg] <= 1'b1;
                                    atime_reg[afree_reg]  <= t_reg;
                                    if (none_reg <= t_reg)
                                        none_reg <= (t_reg == MAXT) ? MAXT : t_reg + 64'd1;
                                end
                            end
                            REQ_ABORT:
                                fvalid_reg[idx_reg] <= 1'b0;
                            REQ_RAISE:
                                if (bound_reg <= t_reg) bound_reg <= t_reg;
                            REQ_QUERY:
                                any_reg <= before_reg;
                            REQ_CLOSE:
                                open_reg <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                S_MIN:
                begin
                    if (do_min_reg)
                    begin
                        if (cnt_reg == CW'(INFLIGHT_DEPTH))
                        begin
                            earliest_reg <= min_reg;
                            cnt_reg <= '0;
                        end
                        else
                        begin
                            if (fvalid_reg[fi] && ftime_reg[fi] < min_reg)
                                min_reg <= ftime_reg[fi];
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    if (do_filter_reg && (!do_min_reg || cnt_reg == CW'(INFLIGHT_DEPTH)))
                        clean_reg <= (do_min_reg ? min_reg : earliest_reg) < bound_reg
                                     ? (do_min_reg ? min_reg : earliest_reg) : bound_reg;
                end
                S_FILTER:
                begin
                    if (do_filter_reg)
                    begin
                        if (cnt_reg == CW'(APPLIED_DEPTH))
                        begin
                            if (avalid_reg == '0) none_reg <= clean_reg;
                        end
                        else
                        begin
                            if (avalid_reg[ai] && atime_reg[ai] < clean_reg)
                                avalid_reg[ai] <= 1'b0;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        ovalid_reg <= 1'b1;
                        odata_reg.status <= st_reg;
                        odata_reg.clean_time <= clean_reg;
                        odata_reg.upper_mark <= none_reg;
                        odata_reg.all_done_before <= (req_reg == REQ_QUERY) &&
                            (t_reg < clean_reg || t_reg < earliest_reg);
                        odata_reg.any_in_flight_at_or_before <= any_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_clean_le_none: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> clean_reg <= none_reg || avalid_reg != '0)
        else $error("watermark order");
endmodule
